// ===== sv/uer_pkg.sv =====
package uer_pkg;

  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM  = 2'd2;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic              trig_out;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance_q4;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/uer_stream_if.sv =====
interface uer_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/uer_div.sv =====
module uer_div import uer_pkg::*; #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [DIST_W-1:0] quot_o,
  output div_stat_t         stat_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DIST_W-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // one quotient bit per cycle, numerator shifted in MSB first
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d = {quo_q[DIST_W-2:0], fits};
    // any bit pushed past the top forces saturation
    ovf_d = ovf_q | quo_q[DIST_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= (den_i == '0);
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign quot_o      = ovf_q ? '1 : quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_one_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// channel  dir  handshake            word
// in_i     in   in_i.valid/ready     start_req, echo_level (one microsecond tick)
// out_o    out  out_o.valid/ready    trig_out, busy_res, done_res, distance_q4
// cfg      in   cfg_we_i (no wait)   cfg_idx_i selects, cfg_wdata_i carries value
//
// An ordinary tick yields a word; a new tick is taken as the last word drains.
// After the tick that ends the last round, input waits on the divider, which yields
// one quotient bit per cycle over the shifted-in numerator.
// Reset is asynchronous, active low; it restores the register defaults and idles.
// A stalled output holds its word and blocks further input until taken.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int SAMPLES         = 5,
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  uer_stream_if.sink            in_i,
  uer_stream_if.source          out_o
);

  localparam int CW    = (ECHO_COUNT_BITS > 16) ? ECHO_COUNT_BITS : 16;
  localparam int SIW   = $clog2(SAMPLES + 1);
  localparam int SW    = ECHO_COUNT_BITS + $clog2(SAMPLES + 1);
  localparam int NUM_W = SW + 4;
  localparam int DEN_W = 8 + $clog2(SAMPLES + 1);

  localparam logic [CW-1:0] ECHO_MAX = CW'((64'd1 << ECHO_COUNT_BITS) - 64'd1);
  localparam logic [CW-1:0] GAP_SAT  = CW'(32'hFFFF);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIG = 3'd1;
  localparam logic [2:0] PH_WAIT = 3'd2;
  localparam logic [2:0] PH_MEAS = 3'd3;
  localparam logic [2:0] PH_GAP  = 3'd4;

  localparam logic S_RUN = 1'b0;
  localparam logic S_DIV = 1'b1;

  logic [7:0]        trig_width_q;
  logic [15:0]       gap_q;
  logic [7:0]        us_per_cm_q;

  logic [2:0]        phase_q, phase_d;
  logic [CW-1:0]     tick_q, tick_d;
  logic [SIW-1:0]    sidx_q, sidx_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic [DIST_W-1:0] dist_q;
  logic              trig;
  logic              fin;

  logic              fsm_q;
  logic              out_valid_q;
  out_word_t         out_q;
  logic              in_fire;

  logic [DIST_W-1:0] quot;
  div_stat_t         div_stat;
  logic [DEN_W-1:0]  den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q <= 8'd20;
      gap_q        <= 16'd50000;
      us_per_cm_q  <= 8'd58;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIG_WIDTH: trig_width_q <= cfg_wdata_i[7:0];
        CFG_GAP:        gap_q        <= cfg_wdata_i;
        CFG_US_PER_CM:  us_per_cm_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (fsm_q == S_RUN) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    sidx_d  = sidx_q;
    sum_d   = sum_q;
    trig    = 1'b0;
    fin     = 1'b0;
    if (phase_q == PH_IDLE && in_i.payload.start_req) begin
      phase_d = PH_TRIG;
      tick_d  = '0;
      sidx_d  = '0;
      sum_d   = '0;
    end
    case (phase_d)
      PH_IDLE: ;
      PH_TRIG: begin
        trig   = 1'b1;
        tick_d = tick_d + CW'(1);
        if (tick_d >= CW'(trig_width_q)) begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end
      end
      PH_WAIT: begin
        if (in_i.payload.echo_level) begin
          phase_d = PH_MEAS;
          tick_d  = CW'(1);
        end
      end
      PH_MEAS: begin
        if (in_i.payload.echo_level) begin
          if (tick_d < ECHO_MAX) tick_d = tick_d + CW'(1);
        end else begin
          sum_d   = sum_d + SW'(tick_d);
          sidx_d  = sidx_d + SIW'(1);
          tick_d  = '0;
          phase_d = PH_GAP;
        end
      end
      PH_GAP: begin
        if (tick_d < GAP_SAT) tick_d = tick_d + CW'(1);
        if (tick_d >= CW'(gap_q)) begin
          tick_d = '0;
          if (sidx_d >= SIW'(SAMPLES)) begin
            fin     = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_TRIG;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      sidx_q  <= '0;
      sum_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      sidx_q  <= sidx_d;
      sum_q   <= sum_d;
    end
  end

  assign den = DEN_W'(us_per_cm_q) * DEN_W'(SAMPLES);

  uer_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && fin),
    .num_i   ({sum_q, 4'b0000}),
    .den_i   (den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_RUN;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
    end else begin
      if (in_fire) begin
        // hold the word until the quotient is ready
        if (fin) fsm_q <= S_DIV;
        out_valid_q <= !fin;
      end else if (fsm_q == S_DIV && div_stat.done) begin
        fsm_q       <= S_RUN;
        out_valid_q <= 1'b1;
        dist_q      <= quot;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !fin) begin
      out_q.trig_out    <= trig;
      out_q.busy_res    <= (phase_d != PH_IDLE);
      out_q.done_res    <= 1'b0;
      out_q.distance_q4 <= dist_q;
    end else if (fsm_q == S_DIV && div_stat.done) begin
      out_q.trig_out    <= 1'b0;
      out_q.busy_res    <= 1'b0;
      out_q.done_res    <= 1'b1;
      out_q.distance_q4 <= quot;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_div_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && fin |=> fsm_q == S_DIV && div_stat.busy)
    else $error("last round did not start the divider");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == S_DIV |-> (div_stat.busy || div_stat.done) && !out_valid_q)
    else $error("waiting on divider that is not running");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> fsm_q == S_DIV)
    else $error("quotient arrived outside the divide wait");

  a_rounds_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sidx_q <= SIW'(SAMPLES))
    else $error("round count past the sample total");

endmodule
